/* sv/wacl_pkg.sv */
// ----------------------------------------------------------------------------
// wacl_pkg
// Shared types, constants and the digit match function for the wildcard
// access list packet filter.
// ----------------------------------------------------------------------------
package wacl_pkg;

    localparam int RULE_DEPTH_DEF = 64;
    localparam int ADDR_DIGITS    = 8;
    localparam int OP_W           = 2;
    localparam int ADDR_W         = 32;
    localparam int MASK_W         = 8;
    localparam int IDX_W          = 6;
    localparam int TOTAL_W        = 16;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_CHECK  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    typedef struct packed {
        t_op               op;
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] dst;
        logic [MASK_W-1:0] smask;
        logic [MASK_W-1:0] dmask;
        logic              permit;
    } t_cmd;

    typedef struct packed {
        logic [ADDR_W-1:0] src_value;
        logic [MASK_W-1:0] src_mask;
        logic [ADDR_W-1:0] dst_value;
        logic [MASK_W-1:0] dst_mask;
        logic              permit;
    } t_rule;

    typedef struct packed {
        logic               permitted;
        logic               rule_hit;
        logic [IDX_W-1:0]   hit_index;
        logic               table_full;
        logic [TOTAL_W-1:0] total;
    } t_result;

    // Digits past ADDR_DIGITS are ignored.
    function automatic logic digits_match(input logic [ADDR_W-1:0] addr,
                                          input logic [ADDR_W-1:0] pat,
                                          input logic [MASK_W-1:0] wild);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < MASK_W; i++) begin
            if (i < ADDR_DIGITS && !wild[i] && addr[4*i +: 4] != pat[4*i +: 4]) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

/* sv/wildcard_acl_packet_filter.sv */
// ----------------------------------------------------------------------------
// wildcard_acl_packet_filter
// Last-match wildcard access list over BCD source/destination addresses:
// clear, append rule and check packet commands, one result per command.
// ----------------------------------------------------------------------------
// channel   direction  handshake          payload
// command   in         start && !busy     i_operation, i_src_address,
//                                          i_dst_address, i_src_wild_mask,
//                                          i_dst_wild_mask, i_rule_permit
// result    out        o_strobe (1 cycle) o_permitted, o_rule_hit, o_hit_index,
//                                          o_table_full, o_permitted_total
//
// Clear, append, unused codes and a check on an empty table are answered from the
// idle state; any other check scans the rule table newest first, one rule per
// cycle through the single read port, up to and including the hit (the whole
// rule count on a miss).
// Two commands queue ahead of execution; busy rises when both slots are full.
// Synchronous active-low reset empties the queue, the table and the counter.
// The receiver cannot stall: each result strobe is taken in its cycle.
module wildcard_acl_packet_filter #(
    parameter int RULE_DEPTH = wacl_pkg::RULE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [wacl_pkg::OP_W-1:0]    i_operation,
    input  logic [wacl_pkg::ADDR_W-1:0]  i_src_address,
    input  logic [wacl_pkg::ADDR_W-1:0]  i_dst_address,
    input  logic [wacl_pkg::MASK_W-1:0]  i_src_wild_mask,
    input  logic [wacl_pkg::MASK_W-1:0]  i_dst_wild_mask,
    input  logic                         i_rule_permit,
    output logic                         o_strobe,
    output logic                         o_permitted,
    output logic                         o_rule_hit,
    output logic [wacl_pkg::IDX_W-1:0]   o_hit_index,
    output logic                         o_table_full,
    output logic [wacl_pkg::TOTAL_W-1:0] o_permitted_total
);

    wacl_pkg::t_cmd    cmd;
    logic              cmd_valid;
    logic              cmd_pop;
    wacl_pkg::t_result res;

    wacl_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_src_address   (i_src_address),
        .i_dst_address   (i_dst_address),
        .i_src_wild_mask (i_src_wild_mask),
        .i_dst_wild_mask (i_dst_wild_mask),
        .i_rule_permit   (i_rule_permit),
        .o_cmd           (cmd),
        .o_cmd_valid     (cmd_valid),
        .i_cmd_pop       (cmd_pop)
    );

    wacl_back #(
        .RULE_DEPTH (RULE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .o_res_valid (o_strobe),
        .o_res       (res)
    );

    assign o_permitted       = res.permitted;
    assign o_rule_hit        = res.rule_hit;
    assign o_hit_index       = res.hit_index;
    assign o_table_full      = res.table_full;
    assign o_permitted_total = res.total;

endmodule

/* sv/wacl_front.sv */
// ----------------------------------------------------------------------------
// wacl_front
// Command intake: takes a transfer, decodes the operation and holds it in a
// two-entry queue until the execution side pops it.
// ----------------------------------------------------------------------------
module wacl_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [wacl_pkg::OP_W-1:0]   i_operation,
    input  logic [wacl_pkg::ADDR_W-1:0] i_src_address,
    input  logic [wacl_pkg::ADDR_W-1:0] i_dst_address,
    input  logic [wacl_pkg::MASK_W-1:0] i_src_wild_mask,
    input  logic [wacl_pkg::MASK_W-1:0] i_dst_wild_mask,
    input  logic                        i_rule_permit,
    output wacl_pkg::t_cmd              o_cmd,
    output logic                        o_cmd_valid,
    input  logic                        i_cmd_pop
);

    wacl_pkg::t_cmd r_queue [2];
    logic           r_wr_ptr, n_wr_ptr;
    logic           r_rd_ptr, n_rd_ptr;
    logic [1:0]     r_fill,   n_fill;
    logic           push;
    logic           pop;
    wacl_pkg::t_cmd cmd_in;

    always_comb begin
        cmd_in.op     = wacl_pkg::t_op'(i_operation);
        cmd_in.src    = i_src_address;
        cmd_in.dst    = i_dst_address;
        cmd_in.smask  = i_src_wild_mask;
        cmd_in.dmask  = i_dst_wild_mask;
        cmd_in.permit = i_rule_permit;
    end

    assign busy        = (r_fill == 2'd2);
    assign push        = start && !busy;
    assign o_cmd_valid = (r_fill != 2'd0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_queue[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop  ? !r_rd_ptr : r_rd_ptr;
        n_fill   = r_fill;
        if (push && !pop) begin
            n_fill = r_fill + 2'd1;
        end else if (pop && !push) begin
            n_fill = r_fill - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

/* sv/wacl_back.sv */
// ----------------------------------------------------------------------------
// wacl_back
// Execution side: rule table memory, rule count, permit counter and the
// newest-first scan, one rule per cycle.
// ----------------------------------------------------------------------------
module wacl_back #(
    parameter int RULE_DEPTH = wacl_pkg::RULE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wacl_pkg::t_cmd    i_cmd,
    input  logic              i_cmd_valid,
    output logic              o_cmd_pop,
    output logic              o_res_valid,
    output wacl_pkg::t_result o_res
);

    localparam int AW = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
    localparam int CW = $clog2(RULE_DEPTH + 1);

    wacl_pkg::t_rule mem [RULE_DEPTH];

    wacl_pkg::t_state                r_state, n_state;
    logic [CW-1:0]                   r_count, n_count;
    logic [wacl_pkg::TOTAL_W-1:0]    r_total, n_total;
    logic                            r_res_valid, n_res_valid;
    wacl_pkg::t_result               r_res, n_res;
    logic [AW-1:0]                   r_idx, n_idx;
    logic [wacl_pkg::ADDR_W-1:0]     r_key_src, n_key_src;
    logic [wacl_pkg::ADDR_W-1:0]     r_key_dst, n_key_dst;
    wacl_pkg::t_rule                 r_rd;
    wacl_pkg::t_rule                 wr_data;
    logic                            mem_we;
    logic                            mem_re;
    logic [AW-1:0]                   rd_addr;
    logic                            take;
    logic                            hit;
    logic                            last;
    logic [wacl_pkg::TOTAL_W-1:0]    total_inc;

    assign take      = (r_state == wacl_pkg::ST_IDLE) && i_cmd_valid;
    assign o_cmd_pop = take;
    assign hit = wacl_pkg::digits_match(r_key_src, r_rd.src_value, r_rd.src_mask) &&
                 wacl_pkg::digits_match(r_key_dst, r_rd.dst_value, r_rd.dst_mask);
    assign last = (r_idx == '0);
    assign total_inc = (r_total == wacl_pkg::TOTAL_MAX) ? r_total
                                                       : r_total + 16'd1;

    always_comb begin
        wr_data.src_value = i_cmd.src;
        wr_data.src_mask  = i_cmd.smask;
        wr_data.dst_value = i_cmd.dst;
        wr_data.dst_mask  = i_cmd.dmask;
        wr_data.permit    = i_cmd.permit;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wacl_pkg::ST_IDLE: begin
                if (take && i_cmd.op == wacl_pkg::OP_CHECK && r_count != '0) begin
                    n_state = wacl_pkg::ST_SCAN;
                end
            end
            wacl_pkg::ST_SCAN: begin
                if (hit || last) begin
                    n_state = wacl_pkg::ST_IDLE;
                end
            end
            default: n_state = wacl_pkg::ST_IDLE;
        endcase
    end

    // datapath and results
    always_comb begin
        n_count     = r_count;
        n_total     = r_total;
        n_idx       = r_idx;
        n_key_src   = r_key_src;
        n_key_dst   = r_key_dst;
        n_res_valid = 1'b0;
        n_res       = r_res;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        rd_addr     = AW'(r_idx - AW'(1));
        unique case (r_state)
            wacl_pkg::ST_IDLE: begin
                if (take) begin
                    n_res = '0;
                    unique case (i_cmd.op)
                        wacl_pkg::OP_CLEAR: begin
                            n_count     = '0;
                            n_total     = '0;
                            n_res_valid = 1'b1;
                        end
                        wacl_pkg::OP_APPEND: begin
                            n_res_valid = 1'b1;
                            n_res.total = r_total;
                            if (r_count < CW'(RULE_DEPTH)) begin
                                mem_we  = 1'b1;
                                n_count = CW'(r_count + CW'(1));
                            end else begin
                                n_res.table_full = 1'b1;
                            end
                        end
                        wacl_pkg::OP_CHECK: begin
                            n_key_src = i_cmd.src;
                            n_key_dst = i_cmd.dst;
                            if (r_count == '0) begin
                                n_res_valid = 1'b1;
                                n_res.total = r_total;
                            end else begin
                                mem_re  = 1'b1;
                                rd_addr = AW'(r_count - CW'(1));
                                n_idx   = AW'(r_count - CW'(1));
                            end
                        end
                        wacl_pkg::OP_NONE: begin
                            n_res_valid = 1'b1;
                            n_res.total = r_total;
                        end
                        default: n_res_valid = 1'b1;
                    endcase
                end
            end
            wacl_pkg::ST_SCAN: begin
                if (hit) begin
                    n_res_valid     = 1'b1;
                    n_res.permitted = r_rd.permit;
                    n_res.rule_hit  = 1'b1;
                    n_res.hit_index = wacl_pkg::IDX_W'(r_idx);
                    n_res.table_full = 1'b0;
                    if (r_rd.permit) begin
                        n_total = total_inc;
                    end
                    n_res.total = r_rd.permit ? total_inc : r_total;
                end else if (last) begin
                    n_res_valid = 1'b1;
                    n_res       = '0;
                    n_res.total = r_total;
                end else begin
                    mem_re = 1'b1;
                    n_idx  = rd_addr;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wacl_pkg::ST_IDLE;
            r_count     <= '0;
            r_total     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_total     <= n_total;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res     <= n_res;
        r_idx     <= n_idx;
        r_key_src <= n_key_src;
        r_key_dst <= n_key_dst;
    end

    // rule table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[AW'(r_count)] <= wr_data;
        end
        if (mem_re) begin
            r_rd <= mem[rd_addr];
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

/* sv/wacl_checker.sv */
// ----------------------------------------------------------------------------
// wacl_checker
// Port-level checks on the filter's results, bound to the top level.
// ----------------------------------------------------------------------------
module wacl_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_strobe,
    input logic                         i_permitted,
    input logic                         i_rule_hit,
    input logic [wacl_pkg::IDX_W-1:0]   i_hit_index,
    input logic                         i_table_full,
    input logic [wacl_pkg::TOTAL_W-1:0] i_permitted_total
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_strobe)
        else $error("result strobe after reset");

    a_permit_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_strobe && i_permitted) |-> i_rule_hit)
        else $error("permit without a matching rule");

    a_miss_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_strobe && !i_rule_hit) |-> (i_hit_index == '0 && !i_permitted))
        else $error("index or verdict set without a hit");

    a_full_not_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_strobe && i_table_full) |-> (!i_rule_hit && !i_permitted))
        else $error("dropped append reported a hit");

    a_permit_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_strobe && i_permitted) |-> (i_permitted_total != '0))
        else $error("permit not counted");

endmodule

bind wildcard_acl_packet_filter wacl_checker u_wacl_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_strobe          (o_strobe),
    .i_permitted       (o_permitted),
    .i_rule_hit        (o_rule_hit),
    .i_hit_index       (o_hit_index),
    .i_table_full      (o_table_full),
    .i_permitted_total (o_permitted_total)
);

/* test/wacl_result_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wacl_result_checker
// Watches the command and result channels of the wildcard access list
// filter. It keeps its own rule table and permit count, works out the result
// of each accepted command and compares every result strobe against the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
module wacl_result_checker
    import wacl_pkg::*;
#(
    parameter int RULE_DEPTH = RULE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic [OP_W-1:0]    i_operation,
    input  logic [ADDR_W-1:0]  i_src_address,
    input  logic [ADDR_W-1:0]  i_dst_address,
    input  logic [MASK_W-1:0]  i_src_wild_mask,
    input  logic [MASK_W-1:0]  i_dst_wild_mask,
    input  logic               i_rule_permit,
    input  logic               i_strobe,
    input  logic               i_permitted,
    input  logic               i_rule_hit,
    input  logic [IDX_W-1:0]   i_hit_index,
    input  logic               i_table_full,
    input  logic [TOTAL_W-1:0] i_permitted_total,
    output int                 o_fail_count,
    output int                 o_pending
);

    t_rule              acl_table [RULE_DEPTH];
    int                 acl_rules;
    logic [TOTAL_W-1:0] permit_total;
    t_result            pending_verdicts [$];
    int                 mismatches = 0;

    assign o_fail_count = mismatches;

    // A digit agrees when its nibbles are equal or the mask marks it as wild.
    function automatic logic address_fits(input logic [ADDR_W-1:0] addr,
                                          input logic [ADDR_W-1:0] pattern,
                                          input logic [MASK_W-1:0] wild);
        logic [ADDR_W-1:0] diff;
        diff = addr ^ pattern;
        for (int d = 0; d < ADDR_DIGITS; d++) begin
            if (diff[4*d +: 4] != 4'h0 && !wild[d]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Applies one command to the local table and returns the verdict it gives.
    function automatic t_result filter_verdict(input t_cmd cmd);
        t_result res;
        res = '0;
        case (cmd.op)
            OP_CLEAR: begin
                acl_rules    = 0;
                permit_total = '0;
            end
            OP_APPEND: begin
                if (acl_rules < RULE_DEPTH) begin
                    acl_table[acl_rules] = '{cmd.src, cmd.smask, cmd.dst, cmd.dmask,
                                             cmd.permit};
                    acl_rules++;
                end else begin
                    res.table_full = 1'b1;
                end
            end
            OP_CHECK: begin
                // newest rule first; the first full match decides
                for (int r = acl_rules - 1; r >= 0; r--) begin
                    if (!res.rule_hit &&
                        address_fits(cmd.src, acl_table[r].src_value, acl_table[r].src_mask) &&
                        address_fits(cmd.dst, acl_table[r].dst_value, acl_table[r].dst_mask)) begin
                        res.rule_hit  = 1'b1;
                        res.hit_index = IDX_W'(r);
                        res.permitted = acl_table[r].permit;
                    end
                end
                if (res.permitted && permit_total != TOTAL_MAX) permit_total++;
            end
            default: ;
        endcase
        res.total = permit_total;
        return res;
    endfunction

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] seen);
        if (seen !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, seen);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_cmd    cmd;
        t_result want;
        if (!i_rst_n) begin
            acl_rules    = 0;
            permit_total = '0;
            pending_verdicts.delete();
        end else begin
            // push before pop, so a same-edge strobe still lines up with the oldest
            if (i_start && !i_busy) begin
                cmd = '{t_op'(i_operation), i_src_address, i_dst_address,
                        i_src_wild_mask, i_dst_wild_mask, i_rule_permit};
                pending_verdicts.push_back(filter_verdict(cmd));
            end
            if (i_strobe) begin
                if (pending_verdicts.size() == 0) begin
                    $display({"%0t: result with no transfer outstanding, expected none, ",
                              "actual %0d %0d %0d %0d %0d"},
                             $time, i_permitted, i_rule_hit, i_hit_index, i_table_full,
                             i_permitted_total);
                    mismatches++;
                end else begin
                    want = pending_verdicts.pop_front();
                    compare_field("permitted", 32'(want.permitted), 32'(i_permitted));
                    compare_field("rule_hit", 32'(want.rule_hit), 32'(i_rule_hit));
                    compare_field("hit_index", 32'(want.hit_index), 32'(i_hit_index));
                    compare_field("table_full", 32'(want.table_full), 32'(i_table_full));
                    compare_field("permitted_total", 32'(want.total),
                                  32'(i_permitted_total));
                end
            end
        end
        o_pending <= pending_verdicts.size();
    end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Command stimulus for the wildcard access list filter: a directed opening,
// random rule tables with packets aimed at stored rules, a run of permitted
// checks, and the final verdict. Checking is done by the checker.
// ----------------------------------------------------------------------------
module tb_top;
    import wacl_pkg::*;

    localparam int IDLE_LIMIT    = 5000;
    localparam int RANDOM_ITEMS  = 1900;
    localparam int PERMIT_CHECKS = 40;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [OP_W-1:0]    i_operation;
    logic [ADDR_W-1:0]  i_src_address;
    logic [ADDR_W-1:0]  i_dst_address;
    logic [MASK_W-1:0]  i_src_wild_mask;
    logic [MASK_W-1:0]  i_dst_wild_mask;
    logic               i_rule_permit;
    logic               o_strobe;
    logic               o_permitted;
    logic               o_rule_hit;
    logic [IDX_W-1:0]   o_hit_index;
    logic               o_table_full;
    logic [TOTAL_W-1:0] o_permitted_total;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    int sent_items  = 0;
    bit no_idle     = 1'b0;

    // copy of the stored patterns, used only to aim packets at real rules
    logic [ADDR_W-1:0] aim_src [RULE_DEPTH_DEF];
    logic [ADDR_W-1:0] aim_dst [RULE_DEPTH_DEF];
    logic [MASK_W-1:0] aim_smask [RULE_DEPTH_DEF];
    logic [MASK_W-1:0] aim_dmask [RULE_DEPTH_DEF];
    int                aim_rules = 0;

    wildcard_acl_packet_filter dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_operation       (i_operation),
        .i_src_address     (i_src_address),
        .i_dst_address     (i_dst_address),
        .i_src_wild_mask   (i_src_wild_mask),
        .i_dst_wild_mask   (i_dst_wild_mask),
        .i_rule_permit     (i_rule_permit),
        .o_strobe          (o_strobe),
        .o_permitted       (o_permitted),
        .o_rule_hit        (o_rule_hit),
        .o_hit_index       (o_hit_index),
        .o_table_full      (o_table_full),
        .o_permitted_total (o_permitted_total)
    );

    wacl_result_checker u_result_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .i_busy            (busy),
        .i_operation       (i_operation),
        .i_src_address     (i_src_address),
        .i_dst_address     (i_dst_address),
        .i_src_wild_mask   (i_src_wild_mask),
        .i_dst_wild_mask   (i_dst_wild_mask),
        .i_rule_permit     (i_rule_permit),
        .i_strobe          (o_strobe),
        .i_permitted       (o_permitted),
        .i_rule_hit        (o_rule_hit),
        .i_hit_index       (o_hit_index),
        .i_table_full      (o_table_full),
        .i_permitted_total (o_permitted_total),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // longest legal quiet stretch is the longest sender gap or a full table scan
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int sender_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(50, 200);
    endfunction

    // mostly BCD digits, now and then any nibble
    function automatic logic [ADDR_W-1:0] random_address();
        logic [ADDR_W-1:0] a;
        if ($urandom_range(0, 3) == 0) return $urandom;
        for (int d = 0; d < ADDR_DIGITS; d++) a[4*d +: 4] = 4'($urandom_range(0, 9));
        return a;
    endfunction

    function automatic logic [MASK_W-1:0] random_wildcards();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return '0;
        if (r == 3) return '1;
        if (r < 6) return 8'hFF << $urandom_range(1, 7);
        if (r < 8) return 8'h01 << $urandom_range(0, 7);
        return MASK_W'($urandom);
    endfunction

    // an address that a pattern accepts; wild digits get any nibble
    function automatic logic [ADDR_W-1:0] address_within(input logic [ADDR_W-1:0] pattern,
                                                         input logic [MASK_W-1:0] wild);
        logic [ADDR_W-1:0] a;
        a = pattern;
        for (int d = 0; d < ADDR_DIGITS; d++) if (wild[d]) a[4*d +: 4] = 4'($urandom);
        return a;
    endfunction

    // one command transfer; start stays high when no gap follows
    task automatic issue_cmd(input t_op op, input logic [ADDR_W-1:0] src,
                             input logic [ADDR_W-1:0] dst, input logic [MASK_W-1:0] smask,
                             input logic [MASK_W-1:0] dmask, input logic permit);
        int gap;
        start           <= 1'b1;
        i_operation     <= op;
        i_src_address   <= src;
        i_dst_address   <= dst;
        i_src_wild_mask <= smask;
        i_dst_wild_mask <= dmask;
        i_rule_permit   <= permit;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sent_items++;
        if (op == OP_CLEAR) begin
            aim_rules = 0;
        end else if (op == OP_APPEND && aim_rules < RULE_DEPTH_DEF) begin
            aim_src[aim_rules]   = src;
            aim_dst[aim_rules]   = dst;
            aim_smask[aim_rules] = smask;
            aim_dmask[aim_rules] = dmask;
            aim_rules++;
        end
        gap = sender_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic random_check();
        int t;
        if (aim_rules > 0 && $urandom_range(0, 9) < 7) begin
            t = $urandom_range(0, aim_rules - 1);
            issue_cmd(OP_CHECK, address_within(aim_src[t], aim_smask[t]),
                      address_within(aim_dst[t], aim_dmask[t]), MASK_W'($urandom),
                      MASK_W'($urandom), 1'($urandom));
        end else begin
            issue_cmd(OP_CHECK, random_address(), random_address(), MASK_W'($urandom),
                      MASK_W'($urandom), 1'($urandom));
        end
    endtask

    // build a table, then probe it; deep tables can run past the last slot
    task automatic rule_session(input bit deep);
        int n_rules;
        int n_probes;
        int r;
        if ($urandom_range(0, 4) != 0)
            issue_cmd(OP_CLEAR, random_address(), random_address(), MASK_W'($urandom),
                      MASK_W'($urandom), 1'($urandom));
        n_rules = deep ? $urandom_range(50, 70) : $urandom_range(0, 10);
        repeat (n_rules)
            issue_cmd(OP_APPEND, random_address(), random_address(), random_wildcards(),
                      random_wildcards(), 1'($urandom_range(0, 1)));
        n_probes = $urandom_range(2, 20);
        repeat (n_probes) begin
            r = $urandom_range(0, 99);
            if (r < 88) random_check();
            else if (r < 96)
                issue_cmd(OP_APPEND, random_address(), random_address(), random_wildcards(),
                          random_wildcards(), 1'($urandom_range(0, 1)));
            else issue_cmd(OP_NONE, $urandom, $urandom, MASK_W'($urandom), MASK_W'($urandom),
                           1'($urandom));
        end
    endtask

    initial begin
        start           = 1'b0;
        i_rst_n         = 1'b0;
        i_operation     = OP_CLEAR;
        i_src_address   = '0;
        i_dst_address   = '0;
        i_src_wild_mask = '0;
        i_dst_wild_mask = '0;
        i_rule_permit   = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed opening
        issue_cmd(OP_CHECK,  32'h0000_0000, 32'h0000_0000, 8'hFF, 8'hFF, 1'b1);
        issue_cmd(OP_NONE,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b1);
        issue_cmd(OP_APPEND, 32'h0000_0000, 32'h9999_9999, 8'h00, 8'h00, 1'b1);
        issue_cmd(OP_CHECK,  32'h0000_0000, 32'h9999_9999, 8'h00, 8'h00, 1'b0);
        issue_cmd(OP_CHECK,  32'h0000_0000, 32'h9999_9998, 8'h00, 8'h00, 1'b0);
        issue_cmd(OP_APPEND, 32'hFFFF_FFFF, 32'h1234_5678, 8'h00, 8'hFF, 1'b0);
        issue_cmd(OP_CHECK,  32'hFFFF_FFFF, 32'hABCD_EF01, 8'h00, 8'h00, 1'b0);
        issue_cmd(OP_APPEND, 32'h1234_5678, 32'h0000_0000, 8'hF0, 8'hFF, 1'b1);
        issue_cmd(OP_CHECK,  32'hABCD_5678, 32'h5555_5555, 8'h00, 8'h00, 1'b0);
        issue_cmd(OP_CHECK,  32'h1234_5679, 32'h9999_9999, 8'h00, 8'h00, 1'b0);
        // catch-all deny shadows the older exact permit
        issue_cmd(OP_APPEND, 32'h0000_0000, 32'h0000_0000, 8'hFF, 8'hFF, 1'b0);
        issue_cmd(OP_CHECK,  32'h0000_0000, 32'h9999_9999, 8'h00, 8'h00, 1'b0);
        issue_cmd(OP_APPEND, 32'hFEDC_BA98, 32'hFFFF_FFFF, 8'h00, 8'h0F, 1'b1);
        issue_cmd(OP_CHECK,  32'hFEDC_BA98, 32'hFFFF_F000, 8'h00, 8'h00, 1'b0);
        issue_cmd(OP_NONE,   32'h0000_0000, 32'h0000_0000, 8'h00, 8'h00, 1'b0);
        issue_cmd(OP_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b1);
        // old entries remain stored but must not be scanned
        issue_cmd(OP_CHECK,  32'h0000_0000, 32'h9999_9999, 8'h00, 8'h00, 1'b0);
        issue_cmd(OP_NONE,   32'h0000_0000, 32'h0000_0000, 8'h00, 8'h00, 1'b0);
        drain_results();

        // random sessions, mostly well formed, some noise
        sent_items = 0;
        rule_session(1'b1);
        drain_results();
        while (sent_items < RANDOM_ITEMS) begin
            no_idle = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) < 8) begin
                rule_session($urandom_range(0, 7) == 0);
            end else begin
                repeat ($urandom_range(3, 15))
                    issue_cmd(t_op'($urandom_range(0, 3)), $urandom, $urandom,
                              MASK_W'($urandom), MASK_W'($urandom), 1'($urandom));
            end
            if ($urandom_range(0, 3) == 0) drain_results();
        end

        // back-to-back permits under a catch-all rule, then a newer deny
        no_idle = 1'b1;
        issue_cmd(OP_CLEAR, '0, '0, '0, '0, 1'b0);
        issue_cmd(OP_APPEND, random_address(), random_address(), 8'hFF, 8'hFF, 1'b1);
        repeat (PERMIT_CHECKS)
            issue_cmd(OP_CHECK, random_address(), random_address(), MASK_W'($urandom),
                      MASK_W'($urandom), 1'($urandom));
        issue_cmd(OP_APPEND, random_address(), random_address(), 8'hFF, 8'hFF, 1'b0);
        issue_cmd(OP_CHECK, random_address(), random_address(), 8'h00, 8'h00, 1'b0);
        issue_cmd(OP_NONE, '0, '0, '0, '0, 1'b0);
        issue_cmd(OP_CLEAR, '0, '0, '0, '0, 1'b0);
        issue_cmd(OP_NONE, '1, '1, '1, '1, 1'b1);

        drain_results();
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* files.f */
sv/wacl_pkg.sv
sv/wacl_front.sv
sv/wacl_back.sv
sv/wildcard_acl_packet_filter.sv
sv/wacl_checker.sv
test/wacl_result_checker.sv
test/tb_top.sv
